@@ design/ctst_pkg.sv @@
// ----------------------------------------------------------------------------
// ctst_pkg
// Shared types and constants for the character stream tokenizer.
// ----------------------------------------------------------------------------
package ctst_pkg;

  localparam int unsigned MaxNestingDefault = 255;
  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned LineW    = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOpSetLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOpSetHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStartLine = 2'd2;

  // result kinds
  localparam logic [1:0] KindByte  = 2'd0;
  localparam logic [1:0] KindEnd   = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  // token classes
  localparam logic [1:0] ClsNumber = 2'd0;
  localparam logic [1:0] ClsIdent  = 2'd1;
  localparam logic [1:0] ClsOper   = 2'd2;
  localparam logic [1:0] ClsBlock  = 2'd3;

  // error codes
  localparam logic [1:0] ErrSecondDot = 2'd0;
  localparam logic [1:0] ErrUnknown   = 2'd1;
  localparam logic [1:0] ErrUntermBlk = 2'd2;
  localparam logic [1:0] ErrNesting   = 2'd3;

  // special characters
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChNewline = 8'h0A;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       out_byte;
    logic [1:0]       token_class;
    logic             starts_token;
    logic             ends_token;
    logic [1:0]       error_code;
    logic [LineW-1:0] line_number;
  } out_item_t;

  // one queue entry: the results of one input beat
  typedef struct packed {
    out_item_t res0;
    out_item_t res1;
    logic      two;
  } q_entry_t;

endpackage

@@ design/ctst_front.sv @@
// ----------------------------------------------------------------------------
// ctst_front
// Classifies each input beat, updates the scan state and builds its results.
// ----------------------------------------------------------------------------
module ctst_front #(
  parameter int unsigned MaxNesting = ctst_pkg::MaxNestingDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ctst_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ctst_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         accept_i,
  input  ctst_pkg::in_item_t           item_i,
  output logic                         q_push_o,
  output ctst_pkg::q_entry_t           q_entry_o
);

  localparam int unsigned DepthW = $clog2(MaxNesting + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MaxNesting);
  localparam logic [DepthW-1:0] DepthOne = DepthW'(1);
  localparam logic [ctst_pkg::LineW-1:0] LineMax = '1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_BLOCK,
    MODE_HALT
  } mode_e;

  mode_e                      mode_q, mode_d;
  logic                       dot_q, dot_d;
  logic [DepthW-1:0]          depth_q, depth_d;
  logic [ctst_pkg::LineW-1:0] line_q, line_d;
  logic [63:0]                op_lo_q, op_hi_q;

  logic [7:0] c;
  logic       eoi;
  logic       is_digit, is_alpha, is_space, is_op;

  // outcome of handling the byte from idle
  logic                ib_v;
  ctst_pkg::out_item_t ib_res;
  mode_e               ib_mode;
  logic                ib_dot_clr;
  logic                ib_depth_set;
  logic                ib_nl;

  ctst_pkg::out_item_t base;
  ctst_pkg::out_item_t res0, res1;
  logic                gen0, two;
  logic                apply_idle;
  logic [1:0]          cls;
  logic [DepthW-1:0]   depth_dec;

  assign c   = item_i.in_byte;
  assign eoi = item_i.end_of_input;

  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  assign is_op    = !c[7] && (c[6] ? op_hi_q[c[5:0]] : op_lo_q[c[5:0]]);

  always_comb begin
    base              = '0;
    base.line_number  = line_q;
  end

  always_comb begin
    ib_v         = 1'b1;
    ib_res       = base;
    ib_res.out_byte = c;
    ib_mode      = MODE_IDLE;
    ib_dot_clr   = 1'b0;
    ib_depth_set = 1'b0;
    ib_nl        = 1'b0;
    priority if (c == ctst_pkg::ChLBrace) begin
      ib_res.token_class  = ctst_pkg::ClsBlock;
      ib_res.starts_token = 1'b1;
      ib_mode             = MODE_BLOCK;
      ib_depth_set        = 1'b1;
    end else if (is_space) begin
      ib_v  = 1'b0;
      ib_nl = (c == ctst_pkg::ChNewline);
    end else if (is_digit) begin
      ib_res.token_class  = ctst_pkg::ClsNumber;
      ib_res.starts_token = 1'b1;
      ib_mode             = MODE_NUM;
      ib_dot_clr          = 1'b1;
    end else if (is_alpha) begin
      ib_res.token_class  = ctst_pkg::ClsIdent;
      ib_res.starts_token = 1'b1;
      ib_mode             = MODE_IDENT;
    end else if (is_op) begin
      ib_res.token_class  = ctst_pkg::ClsOper;
      ib_res.starts_token = 1'b1;
      ib_res.ends_token   = 1'b1;
    end else begin
      ib_res.kind       = ctst_pkg::KindError;
      ib_res.error_code = ctst_pkg::ErrUnknown;
      ib_mode           = MODE_HALT;
    end
  end

  assign depth_dec = (depth_q != '0) ? depth_q - DepthOne : depth_q;

  always_comb begin
    res0       = base;
    res1       = base;
    gen0       = 1'b0;
    two        = 1'b0;
    apply_idle = 1'b0;
    mode_d     = mode_q;
    dot_d      = dot_q;
    depth_d    = depth_q;
    cls        = (mode_q == MODE_NUM) ? ctst_pkg::ClsNumber : ctst_pkg::ClsIdent;
    unique case (mode_q)
      MODE_IDLE: begin
        if (!eoi) begin
          res0       = ib_res;
          gen0       = ib_v;
          apply_idle = 1'b1;
        end
      end
      MODE_NUM, MODE_IDENT: begin
        gen0 = 1'b1;
        if (!eoi && (mode_q == MODE_NUM) && (c == ctst_pkg::ChDot) && dot_q) begin
          res0.kind     = ctst_pkg::KindError;
          res0.out_byte = c;
          res0.error_code = ctst_pkg::ErrSecondDot;
          mode_d        = MODE_HALT;
        end else if (!eoi && (mode_q == MODE_NUM) && (is_digit || c == ctst_pkg::ChDot)) begin
          res0.out_byte    = c;
          res0.token_class = cls;
          if (c == ctst_pkg::ChDot) dot_d = 1'b1;
        end else if (!eoi && (mode_q == MODE_IDENT) &&
                     (is_alpha || is_digit || c == ctst_pkg::ChUnder ||
                      c == ctst_pkg::ChDot)) begin
          res0.out_byte    = c;
          res0.token_class = cls;
        end else begin
          // token ends here; a real byte is then handled from idle
          res0.kind        = ctst_pkg::KindEnd;
          res0.token_class = cls;
          res0.ends_token  = 1'b1;
          mode_d           = MODE_IDLE;
          if (!eoi) begin
            res1       = ib_res;
            two        = ib_v;
            apply_idle = 1'b1;
          end
        end
      end
      MODE_BLOCK: begin
        gen0             = 1'b1;
        res0.token_class = ctst_pkg::ClsBlock;
        res0.out_byte    = c;
        if (eoi) begin
          res0.kind       = ctst_pkg::KindError;
          res0.out_byte   = '0;
          res0.error_code = ctst_pkg::ErrUntermBlk;
          mode_d          = MODE_HALT;
        end else if (c == ctst_pkg::ChLBrace) begin
          if (depth_q >= DepthMax) begin
            res0.kind       = ctst_pkg::KindError;
            res0.error_code = ctst_pkg::ErrNesting;
            mode_d          = MODE_HALT;
          end else begin
            depth_d = depth_q + DepthOne;
          end
        end else if (c == ctst_pkg::ChRBrace) begin
          depth_d = depth_dec;
          if (depth_dec == '0) begin
            res0.ends_token = 1'b1;
            mode_d          = MODE_IDLE;
          end
        end
      end
      MODE_HALT: ;
      default: mode_d = MODE_HALT;
    endcase
    if (apply_idle) begin
      mode_d = ib_mode;
      if (ib_dot_clr) dot_d = 1'b0;
      if (ib_depth_set) depth_d = DepthOne;
    end
  end

  always_comb begin
    line_d = line_q;
    if (accept_i && apply_idle && ib_nl && (line_q != LineMax)) line_d = line_q + 1'b1;
    if (cfg_we_i && (cfg_idx_i == ctst_pkg::CfgStartLine)) begin
      line_d = cfg_data_i[ctst_pkg::LineW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      dot_q   <= 1'b0;
      depth_q <= '0;
      line_q  <= ctst_pkg::LineW'(1);
      op_lo_q <= '0;
      op_hi_q <= '0;
    end else begin
      line_q <= line_d;
      if (accept_i) begin
        mode_q  <= mode_d;
        dot_q   <= dot_d;
        depth_q <= depth_d;
      end
      if (cfg_we_i && (cfg_idx_i == ctst_pkg::CfgOpSetLow))  op_lo_q <= cfg_data_i;
      if (cfg_we_i && (cfg_idx_i == ctst_pkg::CfgOpSetHigh)) op_hi_q <= cfg_data_i;
    end
  end

  // a lone second result moves into the first slot
  always_comb begin
    q_push_o       = accept_i && (gen0 || two);
    q_entry_o.res0 = gen0 ? res0 : res1;
    q_entry_o.res1 = res1;
    q_entry_o.two  = gen0 && two;
  end

endmodule

@@ design/ctst_queue.sv @@
// ----------------------------------------------------------------------------
// ctst_queue
// Short register queue between the classifier and the result side.
// ----------------------------------------------------------------------------
module ctst_queue #(
  parameter int unsigned Depth = ctst_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ctst_pkg::q_entry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output ctst_pkg::q_entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ctst_pkg::q_entry_t slots_q [Depth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [CntW-1:0]    cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ design/ctst_back.sv @@
// ----------------------------------------------------------------------------
// ctst_back
// Result side: hands out queue entries one result beat at a time.
// ----------------------------------------------------------------------------
module ctst_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  ctst_pkg::q_entry_t  q_head_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output ctst_pkg::out_item_t out_item_o
);

  logic sub_q;
  logic beat, last;

  assign empty_o    = q_empty_i;
  assign beat       = pop_i && !q_empty_i;
  assign last       = !q_head_i.two || sub_q;
  assign q_pop_o    = beat && last;
  assign out_item_o = sub_q ? q_head_i.res1 : q_head_i.res0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else if (beat) begin
      sub_q <= !last;
    end
  end

endmodule

@@ design/char_stream_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// char_stream_tokenizer_unit
// Byte-serial tokenizer: tags each source byte with its token role.
// ----------------------------------------------------------------------------
// Results of a beat are registered in the queue when it is taken.
// Throughput: one input beat per cycle while the queue is not full; a beat with two
//   results takes two result beats, the queue (Depth entries) absorbs the difference.
// Reset clears scan state, queue and operator sets; line counter loads 1.
// Halted after an error: beats are still taken and yield no results.
module char_stream_tokenizer_unit #(
  parameter int unsigned MaxNesting = ctst_pkg::MaxNestingDefault,
  parameter int unsigned QueueDepth = ctst_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ctst_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ctst_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  ctst_pkg::in_item_t            in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output ctst_pkg::out_item_t           out_item_o
);

  logic               accept;
  logic               q_push, q_pop, q_empty;
  ctst_pkg::q_entry_t q_entry, q_head;

  assign accept = push && !full;

  ctst_front #(
    .MaxNesting(MaxNesting)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .accept_i  (accept),
    .item_i    (in_item_i),
    .q_push_o  (q_push),
    .q_entry_o (q_entry)
  );

  ctst_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .full_o (full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .head_o (q_head)
  );

  ctst_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_item_o(out_item_o)
  );

endmodule

@@ design/ctst_checker.sv @@
// ----------------------------------------------------------------------------
// ctst_checker
// Port-level checks on the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module ctst_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input ctst_pkg::out_item_t out_item_o
);

  a_not_full_and_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && empty))
    else $error("queue shows full and empty together");

  a_no_beat_from_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !push) |=> empty)
    else $error("result appeared without an input beat");

  a_end_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.kind == ctst_pkg::KindEnd) |->
      (out_item_o.ends_token && out_item_o.out_byte == '0 && !out_item_o.starts_token))
    else $error("malformed token end marker");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.kind == ctst_pkg::KindError) |->
      (!out_item_o.starts_token && !out_item_o.ends_token))
    else $error("error beat flagged as token boundary");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind char_stream_tokenizer_unit ctst_checker u_ctst_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_item_o(out_item_o)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for char_stream_tokenizer_unit. A scoreboard tags every
// accepted source byte in step with the block and checks each result beat in
// order. Directed token strings, line counter limits, deepest brace nesting
// and random token streams under several idle/stall mixes come first; one
// halting error is forced at the end, followed by beats that must be dropped.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MaxNest   = ctst_pkg::MaxNestingDefault;
  localparam int unsigned StuckMax  = 5000;
  localparam logic [1:0]  NoErr     = 2'd0;

  typedef enum logic [2:0] {
    ScanIdle, ScanNumber, ScanIdent, ScanBlock, ScanHalted
  } scan_mode_e;

  logic                          clk_i    = 1'b0;
  logic                          rst_ni   = 1'b0;
  logic                          cfg_we   = 1'b0;
  logic [ctst_pkg::CfgIdxW-1:0]  cfg_idx  = ctst_pkg::CfgOpSetLow;
  logic [ctst_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                          push     = 1'b0;
  logic                          pop      = 1'b0;
  logic                          full;
  logic                          empty;
  ctst_pkg::in_item_t            src_beat = '0;
  ctst_pkg::out_item_t           tok_beat;

  // scoreboard copy of the tokenizer
  logic [63:0] op_lo    = '0;
  logic [63:0] op_hi    = '0;
  logic [15:0] line_cnt = 16'd1;
  scan_mode_e  scan     = ScanIdle;
  logic        dot_seen = 1'b0;
  int unsigned depth    = 0;

  ctst_pkg::out_item_t tokens_due[$];
  ctst_pkg::out_item_t want;
  int unsigned mismatches  = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned stuck_cycles = 0;

  logic [7:0] space_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  always #5 clk_i = ~clk_i;

  char_stream_tokenizer_unit #(
    .MaxNesting(MaxNest)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .in_item_i  (src_beat),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (tok_beat)
  );

  // ---------------------------------------------------------------- predictor
  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_op(logic [7:0] c);
    if (c < 8'd64) return op_lo[c[5:0]];
    if (c < 8'd128) return op_hi[c[5:0]];
    return 1'b0;
  endfunction

  function automatic bit legal_in_idle(logic [7:0] c);
    return is_space(c) || is_digit(c) || is_alpha(c) || c == ctst_pkg::ChLBrace || is_op(c);
  endfunction

  function automatic ctst_pkg::out_item_t mk_tag(logic [1:0] kind, logic [7:0] b,
                                                 logic [1:0] cls, logic st, logic en,
                                                 logic [1:0] err);
    ctst_pkg::out_item_t r;
    r.kind         = kind;
    r.out_byte     = b;
    r.token_class  = cls;
    r.starts_token = st;
    r.ends_token   = en;
    r.error_code   = err;
    r.line_number  = line_cnt;
    return r;
  endfunction

  function automatic void tag_idle_byte(logic [7:0] c);
    if (c == ctst_pkg::ChLBrace) begin
      scan  = ScanBlock;
      depth = 1;
      tokens_due.push_back(mk_tag(ctst_pkg::KindByte, c, ctst_pkg::ClsBlock,
                                  1'b1, 1'b0, NoErr));
    end else if (is_space(c)) begin
      if (c == ctst_pkg::ChNewline && line_cnt != 16'hFFFF) line_cnt++;
    end else if (is_digit(c)) begin
      scan     = ScanNumber;
      dot_seen = 1'b0;
      tokens_due.push_back(mk_tag(ctst_pkg::KindByte, c, ctst_pkg::ClsNumber,
                                  1'b1, 1'b0, NoErr));
    end else if (is_alpha(c)) begin
      scan = ScanIdent;
      tokens_due.push_back(mk_tag(ctst_pkg::KindByte, c, ctst_pkg::ClsIdent,
                                  1'b1, 1'b0, NoErr));
    end else if (is_op(c)) begin
      tokens_due.push_back(mk_tag(ctst_pkg::KindByte, c, ctst_pkg::ClsOper,
                                  1'b1, 1'b1, NoErr));
    end else begin
      scan = ScanHalted;
      tokens_due.push_back(mk_tag(ctst_pkg::KindError, c, ctst_pkg::ClsNumber,
                                  1'b0, 1'b0, ctst_pkg::ErrUnknown));
    end
  endfunction

  function automatic void tag_source_byte(logic [7:0] c, logic eoi);
    logic [1:0] cls;
    case (scan)
      ScanIdle: if (!eoi) tag_idle_byte(c);
      ScanNumber, ScanIdent: begin
        cls = (scan == ScanNumber) ? ctst_pkg::ClsNumber : ctst_pkg::ClsIdent;
        if (!eoi && scan == ScanNumber && is_digit(c)) begin
          tokens_due.push_back(mk_tag(ctst_pkg::KindByte, c, cls, 1'b0, 1'b0, NoErr));
          return;
        end
        if (!eoi && scan == ScanNumber && c == ctst_pkg::ChDot) begin
          if (dot_seen) begin
            scan = ScanHalted;
            tokens_due.push_back(mk_tag(ctst_pkg::KindError, c, ctst_pkg::ClsNumber,
                                        1'b0, 1'b0, ctst_pkg::ErrSecondDot));
          end else begin
            dot_seen = 1'b1;
            tokens_due.push_back(mk_tag(ctst_pkg::KindByte, c, cls, 1'b0, 1'b0, NoErr));
          end
          return;
        end
        if (!eoi && scan == ScanIdent &&
            (is_alpha(c) || is_digit(c) || c == ctst_pkg::ChUnder ||
             c == ctst_pkg::ChDot)) begin
          tokens_due.push_back(mk_tag(ctst_pkg::KindByte, c, cls, 1'b0, 1'b0, NoErr));
          return;
        end
        // terminator: end marker, then the byte is scanned as if idle
        scan = ScanIdle;
        tokens_due.push_back(mk_tag(ctst_pkg::KindEnd, 8'h00, cls, 1'b0, 1'b1, NoErr));
        if (!eoi) tag_idle_byte(c);
      end
      ScanBlock: begin
        if (eoi) begin
          scan = ScanHalted;
          tokens_due.push_back(mk_tag(ctst_pkg::KindError, 8'h00, ctst_pkg::ClsBlock,
                                      1'b0, 1'b0, ctst_pkg::ErrUntermBlk));
        end else if (c == ctst_pkg::ChLBrace && depth >= MaxNest) begin
          scan = ScanHalted;
          tokens_due.push_back(mk_tag(ctst_pkg::KindError, c, ctst_pkg::ClsBlock,
                                      1'b0, 1'b0, ctst_pkg::ErrNesting));
        end else if (c == ctst_pkg::ChRBrace && depth == 1) begin
          depth = 0;
          scan  = ScanIdle;
          tokens_due.push_back(mk_tag(ctst_pkg::KindByte, c, ctst_pkg::ClsBlock,
                                      1'b0, 1'b1, NoErr));
        end else begin
          if (c == ctst_pkg::ChLBrace) depth++;
          if (c == ctst_pkg::ChRBrace) depth--;
          tokens_due.push_back(mk_tag(ctst_pkg::KindByte, c, ctst_pkg::ClsBlock,
                                      1'b0, 1'b0, NoErr));
        end
      end
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------ result check
  function automatic void cmp_field(string what, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %p", $time, tok_beat);
        mismatches++;
      end else begin
        want = tokens_due.pop_front();
        cmp_field("kind", want.kind, tok_beat.kind);
        cmp_field("out_byte", want.out_byte, tok_beat.out_byte);
        cmp_field("token_class", want.token_class, tok_beat.token_class);
        cmp_field("starts_token", want.starts_token, tok_beat.starts_token);
        cmp_field("ends_token", want.ends_token, tok_beat.ends_token);
        cmp_field("error_code", want.error_code, tok_beat.error_code);
        cmp_field("line_number", want.line_number, tok_beat.line_number);
      end
    end
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckMax) begin
        $display("%0t: no beat moved for %0d cycles", $time, StuckMax);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_beat(logic [7:0] c, logic eoi);
    while ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    src_beat <= '{in_byte: c, end_of_input: eoi};
    do @(posedge clk_i); while (full);
    tag_source_byte(c, eoi);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // bring the stream back to idle, then let the block run dry
  task automatic quiesce();
    while (scan == ScanNumber || scan == ScanIdent) send_beat(8'($urandom), 1'b1);
    while (scan == ScanBlock) send_beat(ctst_pkg::ChRBrace, 1'b0);
    push <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [63:0] lo, logic [63:0] hi, logic [15:0] ln, bit with_line);
    cfg_we   <= 1'b1;
    cfg_idx  <= ctst_pkg::CfgOpSetLow;
    cfg_data <= lo;
    @(posedge clk_i);
    op_lo     = lo;
    cfg_idx  <= ctst_pkg::CfgOpSetHigh;
    cfg_data <= hi;
    @(posedge clk_i);
    op_hi = hi;
    if (with_line) begin
      cfg_idx  <= ctst_pkg::CfgStartLine;
      cfg_data <= ctst_pkg::CfgDataW'(ln);
      @(posedge clk_i);
      line_cnt = ln;
    end
    cfg_we <= 1'b0;
  endtask

  // ------------------------------------------------------ random generation
  function automatic logic [7:0] pick_op();
    logic [7:0] c;
    repeat (500) begin
      c = 8'($urandom_range(0, 127));
      if (is_op(c) && !is_space(c) && !is_digit(c) && !is_alpha(c) &&
          c != ctst_pkg::ChLBrace)
        return c;
    end
    return "a";
  endfunction

  // a byte that closes a number or identifier and is legal to scan from idle
  function automatic logic [7:0] pick_stop(bit in_number);
    logic [7:0] c;
    repeat (500) begin
      c = 8'($urandom_range(0, 127));
      if (legal_in_idle(c) && !is_digit(c) && c != ctst_pkg::ChDot &&
          (in_number || (!is_alpha(c) && c != ctst_pkg::ChUnder)))
        return c;
    end
    return 8'h20;
  endfunction

  function automatic logic [7:0] pick_letter();
    return ($urandom_range(0, 1) != 0) ? 8'("a" + $urandom_range(0, 25))
                                       : 8'("A" + $urandom_range(0, 25));
  endfunction

  task automatic send_random_beat();
    logic [7:0]  c;
    logic        eoi;
    int unsigned r;
    eoi = 1'b0;
    r   = $urandom_range(0, 99);
    c   = 8'($urandom);
    case (scan)
      ScanIdle: begin
        if (r < 8) eoi = 1'b1;
        else if (r < 22) c = space_chars[$urandom_range(0, 5)];
        else if (r < 42) c = 8'("0" + $urandom_range(0, 9));
        else if (r < 64) c = pick_letter();
        else if (r < 72) c = ctst_pkg::ChLBrace;
        else c = pick_op();
      end
      ScanNumber: begin
        if (r < 50) c = 8'("0" + $urandom_range(0, 9));
        else if (r < 58 && !dot_seen) c = ctst_pkg::ChDot;
        else if (r < 66) eoi = 1'b1;
        else c = pick_stop(1'b1);
      end
      ScanIdent: begin
        if (r < 30) c = pick_letter();
        else if (r < 45) c = 8'("0" + $urandom_range(0, 9));
        else if (r < 50) c = ctst_pkg::ChUnder;
        else if (r < 55) c = ctst_pkg::ChDot;
        else if (r < 63) eoi = 1'b1;
        else c = pick_stop(1'b0);
      end
      ScanBlock: begin
        if (r < 10) c = ctst_pkg::ChLBrace;
        else if (r < 24) c = ctst_pkg::ChRBrace;
        else if (r < 30) c = ctst_pkg::ChNewline;
        if (c == ctst_pkg::ChLBrace && depth >= MaxNest) c = ctst_pkg::ChRBrace;
      end
      default: ;
    endcase
    send_beat(c, eoi);
  endtask

  // ------------------------------------------------------------------ tests
  task automatic test_directed();
    logic [127:0] ops;
    string        op_chars;
    logic [7:0]   oc;
    op_chars = "+.;_}";
    ops      = '0;
    for (int i = 0; i < op_chars.len(); i++) begin
      oc           = op_chars[i];
      ops[oc[6:0]] = 1'b1;
    end
    gap_pct   = 0;
    stall_pct = 0;
    quiesce();
    write_cfg(ops[63:0], ops[127:64], 16'd1, 1'b1);
    // number with dot cut by an operator, identifier with '_' and '.'
    send_text("12.5+ab_.9 \n{");
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text("{\n}}7");
    send_beat(8'hFF, 1'b1);   // end of input inside a number
    send_beat(8'h00, 1'b1);   // end of input while idle: dropped
    send_text("q");
    send_beat(8'h5A, 1'b1);
    send_text("._}");         // bitmap operators outside any token
  endtask

  task automatic test_line_limits();
    gap_pct   = 50;
    stall_pct = 50;
    quiesce();
    write_cfg('1, '1, 16'hFFFE, 1'b1);
    send_text("\n\n\nx9;");
    send_beat(8'h00, 1'b0);   // operator when every bit is set
    quiesce();
    write_cfg('0, '0, 16'h0000, 1'b1);
    send_text("42 a\n");
  endtask

  task automatic test_deep_nesting();
    gap_pct   = 0;
    stall_pct = 50;
    quiesce();
    repeat (MaxNest) send_beat(ctst_pkg::ChLBrace, 1'b0);
    send_beat(8'h80, 1'b0);
    repeat (MaxNest) send_beat(ctst_pkg::ChRBrace, 1'b0);
  endtask

  task automatic test_random_phase(int unsigned gap, int unsigned stall, int unsigned n);
    quiesce();
    write_cfg({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
              $urandom_range(0, 1) != 0);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (n) send_random_beat();
  endtask

  // one error per run: it halts the block for good
  task automatic test_halt();
    int unsigned pick;
    gap_pct   = 36;
    stall_pct = 36;
    quiesce();
    pick = $urandom_range(0, 3);
    case (pick)
      0: send_text("1.2.");
      1: send_beat(8'($urandom_range(128, 255)), 1'b0);
      2: begin
        send_text("{a");
        send_beat(8'h00, 1'b1);
      end
      default: repeat (MaxNest + 1) send_beat(ctst_pkg::ChLBrace, 1'b0);
    endcase
    repeat (12) send_beat(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_line_limits();
    test_deep_nesting();
    test_random_phase(0, 0, 200);
    test_random_phase(50, 0, 200);
    test_random_phase(0, 50, 200);
    test_random_phase(36, 36, 200);
    test_halt();
    push <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
design/ctst_pkg.sv
design/ctst_front.sv
design/ctst_queue.sv
design/ctst_back.sv
design/char_stream_tokenizer_unit.sv
design/ctst_checker.sv
tb/sv/tb.sv
